FILE: hw/rtl/dsfp_pkg.sv
package dsfp_pkg;

   localparam int TOKEN_BUFFER_DEPTH = 32;
   localparam int IDX_W = $clog2(TOKEN_BUFFER_DEPTH);
   localparam int CNT_W = $clog2(TOKEN_BUFFER_DEPTH + 1);

   localparam int BYTE_W = 8;
   localparam int VALUE_W = 32;
   localparam int SLOT_W = 31;
   localparam int LEN_W = 7;
   localparam int SEP_W = 2;
   localparam int CAP_W = 6;
   localparam int TOKLEN_W = 6;
   localparam int STATUS_W = 3;

   localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;
   localparam logic [SEP_W-1:0] SEP_MAX = 2'd3;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd33;
   localparam logic [VALUE_W-1:0] VALUE_SAT = 32'hffff_ffff;
   localparam logic [VALUE_W-1:0] SLOT_MAX = 32'h7fff_ffff;
   localparam logic [BYTE_W-1:0] CHAR_DOT = 8'h2e;
   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

   localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_TOKEN = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_GEN = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_BAD_GEN = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_TOKEN_LONG = 3'd6;

   typedef struct packed {
      logic nonempty;
      logic overflow;
      logic nondigit;
   } seg_flags_type;

   typedef logic [TOKEN_BUFFER_DEPTH-1:0][BYTE_W-1:0] token_bytes_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0] slot;
      logic [VALUE_W-1:0] generation;
      logic [TOKLEN_W-1:0] token_length;
   } verdict_type;

endpackage

FILE: hw/rtl/dsfp_parse.sv
module dsfp_parse (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [dsfp_pkg::BYTE_W-1:0] subject_byte,
   input  logic csr_wr_en,
   input  logic [dsfp_pkg::CAP_W-1:0] csr_wr_data,
   output dsfp_pkg::verdict_type verdict,
   output dsfp_pkg::token_bytes_type token_bytes,
   input  logic end_of_subject
);

   logic [dsfp_pkg::CAP_W-1:0] cap_ff;
   logic [dsfp_pkg::VALUE_W-1:0] seg_value_ff, seg_value_in;
   dsfp_pkg::seg_flags_type seg_flags_ff, seg_flags_in;
   logic [dsfp_pkg::LEN_W-1:0] seg_len_ff, seg_len_in;
   dsfp_pkg::token_bytes_type seg_bytes_ff, seg_bytes_in;
   logic [dsfp_pkg::VALUE_W-1:0] gen_value_ff, gen_value_in;
   dsfp_pkg::seg_flags_type gen_flags_ff, gen_flags_in;
   logic [dsfp_pkg::VALUE_W-1:0] slot_value_ff, slot_value_in;
   dsfp_pkg::seg_flags_type slot_flags_ff, slot_flags_in;
   logic [dsfp_pkg::SEP_W-1:0] sep_count_ff, sep_count_in;

   logic is_dot;
   logic is_digit;
   logic [dsfp_pkg::VALUE_W+3:0] acc;
   logic [dsfp_pkg::STATUS_W-1:0] status;

   assign is_dot = (subject_byte == dsfp_pkg::CHAR_DOT);
   assign is_digit = (subject_byte >= dsfp_pkg::CHAR_ZERO) &&
                     (subject_byte <= dsfp_pkg::CHAR_NINE);
   // value * 10 + digit
   assign acc = {1'b0, seg_value_ff, 3'b000} + {3'b000, seg_value_ff, 1'b0} +
                {32'd0, subject_byte[3:0]};

   always_comb begin
      seg_value_in = seg_value_ff;
      seg_flags_in = seg_flags_ff;
      seg_len_in = seg_len_ff;
      seg_bytes_in = seg_bytes_ff;
      gen_value_in = gen_value_ff;
      gen_flags_in = gen_flags_ff;
      slot_value_in = slot_value_ff;
      slot_flags_in = slot_flags_ff;
      sep_count_in = sep_count_ff;
      if (is_dot) begin
         slot_value_in = gen_value_ff;
         slot_flags_in = gen_flags_ff;
         gen_value_in = seg_value_ff;
         gen_flags_in = seg_flags_ff;
         seg_value_in = '0;
         seg_flags_in = '0;
         seg_len_in = '0;
         if (sep_count_ff != dsfp_pkg::SEP_MAX) begin
            sep_count_in = sep_count_ff + 1'b1;
         end
      end else begin
         if (seg_len_ff < dsfp_pkg::LEN_W'(dsfp_pkg::TOKEN_BUFFER_DEPTH)) begin
            seg_bytes_in[seg_len_ff[dsfp_pkg::IDX_W-1:0]] = subject_byte;
         end
         if (seg_len_ff != dsfp_pkg::LEN_MAX) begin
            seg_len_in = seg_len_ff + 1'b1;
         end
         seg_flags_in.nonempty = 1'b1;
         if (!is_digit) begin
            seg_flags_in.nondigit = 1'b1;
         end else if (!seg_flags_ff.overflow) begin
            if (acc[dsfp_pkg::VALUE_W+3:dsfp_pkg::VALUE_W] != 4'd0) begin
               seg_flags_in.overflow = 1'b1;
               seg_value_in = dsfp_pkg::VALUE_SAT;
            end else begin
               seg_value_in = acc[dsfp_pkg::VALUE_W-1:0];
            end
         end
      end
   end

   // checks on the state as it stands after this byte
   always_comb begin
      if (sep_count_in == 2'd0 || seg_len_in == '0) begin
         status = dsfp_pkg::STATUS_NO_TOKEN;
      end else if (sep_count_in < 2'd2 || !gen_flags_in.nonempty) begin
         status = dsfp_pkg::STATUS_NO_GEN;
      end else if (sep_count_in < 2'd3 || !slot_flags_in.nonempty) begin
         status = dsfp_pkg::STATUS_NO_SLOT;
      end else if (slot_flags_in.nondigit || slot_flags_in.overflow ||
                   slot_value_in > dsfp_pkg::SLOT_MAX) begin
         status = dsfp_pkg::STATUS_BAD_SLOT;
      end else if (gen_flags_in.nondigit || gen_flags_in.overflow) begin
         status = dsfp_pkg::STATUS_BAD_GEN;
      end else if (seg_len_in >= {1'b0, cap_ff} ||
                   seg_len_in > dsfp_pkg::LEN_W'(dsfp_pkg::TOKEN_BUFFER_DEPTH)) begin
         status = dsfp_pkg::STATUS_TOKEN_LONG;
      end else begin
         status = dsfp_pkg::STATUS_OK;
      end
   end

   always_comb begin
      verdict.status = status;
      verdict.slot = slot_value_in[dsfp_pkg::SLOT_W-1:0];
      verdict.generation = gen_value_in;
      verdict.token_length = seg_len_in[dsfp_pkg::TOKLEN_W-1:0];
   end

   assign token_bytes = seg_bytes_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= dsfp_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_value_ff <= '0;
         seg_flags_ff <= '0;
         seg_len_ff <= '0;
         gen_value_ff <= '0;
         gen_flags_ff <= '0;
         slot_value_ff <= '0;
         slot_flags_ff <= '0;
         sep_count_ff <= '0;
      end else if (accept) begin
         if (end_of_subject) begin
            seg_value_ff <= '0;
            seg_flags_ff <= '0;
            seg_len_ff <= '0;
            gen_value_ff <= '0;
            gen_flags_ff <= '0;
            slot_value_ff <= '0;
            slot_flags_ff <= '0;
            sep_count_ff <= '0;
         end else begin
            seg_value_ff <= seg_value_in;
            seg_flags_ff <= seg_flags_in;
            seg_len_ff <= seg_len_in;
            gen_value_ff <= gen_value_in;
            gen_flags_ff <= gen_flags_in;
            slot_value_ff <= slot_value_in;
            slot_flags_ff <= slot_flags_in;
            sep_count_ff <= sep_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seg_bytes_ff <= seg_bytes_in;
      end
   end

endmodule

FILE: hw/rtl/dsfp_emit.sv
module dsfp_emit (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  dsfp_pkg::verdict_type verdict,
   input  dsfp_pkg::token_bytes_type token_bytes,
   output logic busy,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [dsfp_pkg::STATUS_W-1:0] rsp_status,
   output logic [dsfp_pkg::SLOT_W-1:0] rsp_slot,
   output logic [dsfp_pkg::VALUE_W-1:0] rsp_generation,
   output logic [dsfp_pkg::TOKLEN_W-1:0] rsp_token_length,
   output logic [dsfp_pkg::BYTE_W-1:0] rsp_token_byte,
   output logic rsp_last
);

   logic valid_ff, valid_in;
   logic [dsfp_pkg::CNT_W-1:0] remain_ff, remain_in;
   dsfp_pkg::verdict_type fields_ff, fields_in;
   dsfp_pkg::token_bytes_type tok_bytes_ff, tok_bytes_in;
   logic take;
   logic ok;

   assign take = valid_ff && !rsp_stall;
   assign ok = (verdict.status == dsfp_pkg::STATUS_OK);

   always_comb begin
      valid_in = valid_ff;
      remain_in = remain_ff;
      fields_in = fields_ff;
      tok_bytes_in = tok_bytes_ff;
      if (load) begin
         valid_in = 1'b1;
         if (ok) begin
            fields_in = verdict;
            remain_in = dsfp_pkg::CNT_W'(verdict.token_length);
            tok_bytes_in = token_bytes;
         end else begin
            fields_in = '0;
            fields_in.status = verdict.status;
            remain_in = dsfp_pkg::CNT_W'(1);
            tok_bytes_in = '0;
         end
      end else if (take) begin
         if (remain_ff == dsfp_pkg::CNT_W'(1)) begin
            valid_in = 1'b0;
         end
         remain_in = remain_ff - 1'b1;
         tok_bytes_in = {{dsfp_pkg::BYTE_W{1'b0}},
                         tok_bytes_ff[dsfp_pkg::TOKEN_BUFFER_DEPTH-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         remain_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      fields_ff <= fields_in;
      tok_bytes_ff <= tok_bytes_in;
   end

   // free again once the last item of the run is taken
   assign busy = valid_ff && !(take && (remain_ff == dsfp_pkg::CNT_W'(1)));
   assign rsp_valid = valid_ff;
   assign rsp_status = fields_ff.status;
   assign rsp_slot = fields_ff.slot;
   assign rsp_generation = fields_ff.generation;
   assign rsp_token_length = fields_ff.token_length;
   assign rsp_token_byte = tok_bytes_ff[0];
   assign rsp_last = (remain_ff == dsfp_pkg::CNT_W'(1));

endmodule

FILE: hw/rtl/dotted_subject_field_parser.sv
// dotted subject field parser
// req channel: one subject byte per item, req_end_of_subject on the final byte.
// the last three dot-separated segments are taken as slot, generation and token.
// rsp channel: per subject either one item per token byte (status ok, slot,
// generation, token length, byte, rsp_last on the final byte) or a single
// error item with status set and all other fields zero, rsp_last high.
// csr port: csr_wr_en / csr_wr_data write the token capacity (reset 33);
// write only while no subject is in progress and no result is pending.
// throughput: one byte per cycle; bytes that do not end a subject are always
// taken. a final byte is held off (req_stall) until the last item of the
// previous subject's run is taken, since the run buffer holds one subject.
// latency: the first result item is valid the cycle after the final byte is
// accepted; a run then delivers one item per cycle while rsp_stall is low.
// rsp_stall holds the current item and its fields unchanged.
// reset (synchronous): clears the parse state, drops any pending run and
// restores the capacity to 33.
module dotted_subject_field_parser (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [dsfp_pkg::BYTE_W-1:0] req_subject_byte,
   input  logic req_end_of_subject,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [dsfp_pkg::STATUS_W-1:0] rsp_status,
   output logic [dsfp_pkg::SLOT_W-1:0] rsp_slot,
   output logic [dsfp_pkg::VALUE_W-1:0] rsp_generation,
   output logic [dsfp_pkg::TOKLEN_W-1:0] rsp_token_length,
   output logic [dsfp_pkg::BYTE_W-1:0] rsp_token_byte,
   output logic rsp_last,
   input  logic csr_wr_en,
   input  logic [dsfp_pkg::CAP_W-1:0] csr_wr_data
);

   logic busy;
   logic accept;
   dsfp_pkg::verdict_type verdict;
   dsfp_pkg::token_bytes_type token_bytes;

   assign req_stall = req_end_of_subject && busy;
   assign accept = req_valid && !req_stall;

   dsfp_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .subject_byte   (req_subject_byte),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .verdict        (verdict),
      .token_bytes    (token_bytes),
      .end_of_subject (req_end_of_subject)
   );

   dsfp_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .load             (accept && req_end_of_subject),
      .verdict          (verdict),
      .token_bytes      (token_bytes),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_generation   (rsp_generation),
      .rsp_token_length (rsp_token_length),
      .rsp_token_byte   (rsp_token_byte),
      .rsp_last         (rsp_last)
   );

endmodule
